FILE: hdl/gic_pkg.sv
// Shared types and constants for the grid index converter.
package gic_pkg;
   localparam int LIN_W    = 30;
   localparam int CRD_W    = 10;
   localparam int PTS_W    = 11;
   localparam int STEP_W   = 24;
   localparam int POS_W    = 34;
   localparam int PLANE_W  = 2 * PTS_W;
   localparam int ACC_W    = 32;
   localparam logic [PTS_W-1:0] MAX_PTS = 11'd1024;

   // pipeline layout: mode 1 chain, then z digits, then y digits, then finish
   localparam int ST_Z0  = 3;
   localparam int ST_Y0  = ST_Z0 + CRD_W;
   localparam int ST_FIN = ST_Y0 + CRD_W;
   localparam int NSTG   = ST_FIN + 1;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 168;
   localparam int ADDR_W     = 5;

   typedef enum logic [2:0] {
      REG_DIMS   = 3'd0,
      REG_PTS_X  = 3'd1,
      REG_PTS_Y  = 3'd2,
      REG_PTS_Z  = 3'd3,
      REG_STEP_X = 3'd4,
      REG_STEP_Y = 3'd5,
      REG_STEP_Z = 3'd6,
      REG_NONE   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic             valid;
      logic             mode;
      logic             err;
      logic [LIN_W-1:0] lin;
      logic [CRD_W-1:0] x;
      logic [CRD_W-1:0] y;
      logic [CRD_W-1:0] z;
      logic [ACC_W-1:0] acc;
      logic [LIN_W-1:0] rem;
   } stage_type;
endpackage

FILE: hdl/grid_index_converter_top.sv
// Top level: row-major grid index <-> x/y/z coordinate converter.
// Stage 0 loads at the req accepting edge, followed by 23 more pipeline stages,
// then the output reg that drives rsp valid.
// Throughput: one item per cycle; the whole pipe advances whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Division uses one restoring quotient digit per stage (10 for z, 10 for y).
// Reset (synchronous, active high) clears all valid bits and loads default registers.
module grid_index_converter_top (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: linear_in[29:0], x_in[39:30], y_in[49:40], z_in[59:50], zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gic_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: linear_out[29:0], x_out[39:30], y_out[49:40], z_out[59:50],
   // on_boundary[60], pos_x[94:61], pos_y[128:95], pos_z[162:129],
   // range_error[163], zero fill
   output logic [gic_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gic_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import gic_pkg::*;

   // ---------------- configuration registers ----------------
   logic [1:0]        dims_ff;
   logic [PTS_W-1:0]  pts_x_ff, pts_y_ff, pts_z_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff, step_z_ff;
   reg_index_type     csr_idx;
   logic              csr_wr;

   assign csr_idx    = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= 2'd3;
         pts_x_ff  <= MAX_PTS;
         pts_y_ff  <= MAX_PTS;
         pts_z_ff  <= MAX_PTS;
         step_x_ff <= 24'd65536;
         step_y_ff <= 24'd65536;
         step_z_ff <= 24'd65536;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DIMS:   dims_ff   <= csr_pwdata[1:0];
            REG_PTS_X:  pts_x_ff  <= csr_pwdata[PTS_W-1:0];
            REG_PTS_Y:  pts_y_ff  <= csr_pwdata[PTS_W-1:0];
            REG_PTS_Z:  pts_z_ff  <= csr_pwdata[PTS_W-1:0];
            REG_STEP_X: step_x_ff <= csr_pwdata[STEP_W-1:0];
            REG_STEP_Y: step_y_ff <= csr_pwdata[STEP_W-1:0];
            REG_STEP_Z: step_z_ff <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIMS:   csr_prdata = {30'd0, dims_ff};
         REG_PTS_X:  csr_prdata = {21'd0, pts_x_ff};
         REG_PTS_Y:  csr_prdata = {21'd0, pts_y_ff};
         REG_PTS_Z:  csr_prdata = {21'd0, pts_z_ff};
         REG_STEP_X: csr_prdata = {8'd0, step_x_ff};
         REG_STEP_Y: csr_prdata = {8'd0, step_y_ff};
         REG_STEP_Z: csr_prdata = {8'd0, step_z_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- effective axis sizes ----------------
   // zero dimensions means one axis; unused axes count as size 1;
   // zero points means 1, anything above the max saturates
   logic             use_y, use_z;
   logic [PTS_W-1:0] nx, ny, nz;

   function automatic logic [PTS_W-1:0] axis_size(input logic [PTS_W-1:0] p,
                                                  input logic act);
      logic [PTS_W-1:0] r;
      if (!act || p == '0) r = PTS_W'(1);
      else if (p > MAX_PTS) r = MAX_PTS;
      else r = p;
      return r;
   endfunction

   assign use_y = (dims_ff == 2'd2) || (dims_ff == 2'd3);
   assign use_z = (dims_ff == 2'd3);
   assign nx    = axis_size(pts_x_ff, 1'b1);
   assign ny    = axis_size(pts_y_ff, use_y);
   assign nz    = axis_size(pts_z_ff, use_z);

   // plane and volume sizes, registered; the volume register follows the plane register
   logic [PLANE_W-1:0] plane_ff;
   logic [LIN_W:0]     total_ff;

   always_ff @(posedge clock) begin
      plane_ff <= PLANE_W'(nx) * PLANE_W'(ny);
      total_ff <= (LIN_W+1)'(plane_ff) * (LIN_W+1)'(nz);
   end

   // ---------------- pipeline ----------------
   logic      adv;
   stage_type pipe_ff [NSTG];
   stage_type pipe_in [NSTG];
   stage_type first_stage;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // entry: unused axis inputs are dropped here
   always_comb begin
      first_stage       = '0;
      first_stage.valid = req_tvalid;
      first_stage.mode  = req_tuser;
      first_stage.lin   = req_tdata[LIN_W-1:0];
      first_stage.x     = req_tdata[LIN_W +: CRD_W];
      first_stage.y     = use_y ? req_tdata[LIN_W+CRD_W +: CRD_W] : '0;
      first_stage.z     = use_z ? req_tdata[LIN_W+2*CRD_W +: CRD_W] : '0;
   end

   always_comb begin
      stage_type          c;
      logic [LIN_W:0]     dv;
      logic [LIN_W:0]     rw;
      pipe_in[0] = first_stage;
      dv = '0;
      rw = '0;
      for (int s = 0; s < NSTG - 1; s++) begin
         c = pipe_ff[s];
         if (s == 0) begin
            // ny*z + y
            c.acc = ACC_W'(ny) * ACC_W'(pipe_ff[s].z) + ACC_W'(pipe_ff[s].y);
         end else if (s == 1) begin
            // nx*(...)
            c.acc = ACC_W'(nx) * pipe_ff[s].acc;
            if (pipe_ff[s].mode)
               c.err = ({1'b0, pipe_ff[s].x} >= nx) || ({1'b0, pipe_ff[s].y} >= ny)
                       || ({1'b0, pipe_ff[s].z} >= nz);
            else
               c.err = {1'b0, pipe_ff[s].lin} >= total_ff;
         end else if (s == 2) begin
            c.acc = pipe_ff[s].acc + ACC_W'(pipe_ff[s].x);
            c.rem = pipe_ff[s].lin;
         end else if (s < ST_Y0) begin
            // z quotient digit, MSB first
            dv = (LIN_W+1)'(plane_ff) << (CRD_W - 1 - (s - ST_Z0));
            rw = {1'b0, pipe_ff[s].rem};
            if (!pipe_ff[s].mode) begin
               if (rw >= dv) begin
                  c.rem = LIN_W'(rw - dv);
                  c.z   = {pipe_ff[s].z[CRD_W-2:0], 1'b1};
               end else begin
                  c.z   = {pipe_ff[s].z[CRD_W-2:0], 1'b0};
               end
            end
         end else begin
            // y quotient digit from the in-plane remainder
            dv = (LIN_W+1)'(nx) << (CRD_W - 1 - (s - ST_Y0));
            rw = {1'b0, pipe_ff[s].rem};
            if (!pipe_ff[s].mode) begin
               if (rw >= dv) begin
                  c.rem = LIN_W'(rw - dv);
                  c.y   = {pipe_ff[s].y[CRD_W-2:0], 1'b1};
               end else begin
                  c.y   = {pipe_ff[s].y[CRD_W-2:0], 1'b0};
               end
            end
         end
         pipe_in[s+1] = c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) pipe_ff[s].valid <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < NSTG; s++) pipe_ff[s] <= pipe_in[s];
      end
   end

   // ---------------- finish stage: positions, boundary, muxing ----------------
   always_comb begin
      stage_type        f;
      logic [CRD_W-1:0] fx;
      logic [LIN_W-1:0] flin;
      logic [POS_W-1:0] px, py, pz;
      logic             bnd;
      f    = pipe_ff[ST_FIN];
      fx   = f.mode ? f.x : f.rem[CRD_W-1:0];
      flin = f.mode ? f.acc[LIN_W-1:0] : f.lin;
      px   = POS_W'(fx) * POS_W'(step_x_ff);
      py   = use_y ? POS_W'(f.y) * POS_W'(step_y_ff) : '0;
      pz   = use_z ? POS_W'(f.z) * POS_W'(step_z_ff) : '0;
      bnd  = (fx == '0) || ({1'b0, fx} == nx - PTS_W'(1))
             || (use_y && ((f.y == '0) || ({1'b0, f.y} == ny - PTS_W'(1))))
             || (use_z && ((f.z == '0) || ({1'b0, f.z} == nz - PTS_W'(1))));
      rsp_tvalid_in = f.valid;
      if (f.err)
         rsp_tdata_in = {4'd0, 1'b1, 163'd0};
      else
         rsp_tdata_in = {4'd0, 1'b0, pz, py, px, bnd, f.z, f.y, fx, flin};
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (adv) rsp_tvalid_ff <= rsp_tvalid_in;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the grid index converter.
`timescale 1ns / 100ps

module tb_top;
   import gic_pkg::*;

   localparam int LATENCY     = 25;
   localparam int CYCLE_LIMIT = 400000;

   // one expected converter result, last field in the lowest bits
   typedef struct packed {
      logic             err;
      logic [POS_W-1:0] pz;
      logic [POS_W-1:0] py;
      logic [POS_W-1:0] px;
      logic             boundary;
      logic [CRD_W-1:0] z;
      logic [CRD_W-1:0] y;
      logic [CRD_W-1:0] x;
      logic [LIN_W-1:0] lin;
   } point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shadow copy of the register file
   logic [1:0]        grid_dims;
   logic [PTS_W-1:0]  grid_pts [3];
   logic [STEP_W-1:0] grid_step [3];

   point_type expected_points[$];
   int        mismatch_count = 0;
   int        items_sent = 0;
   int        points_seen = 0;
   int        error_points = 0;
   int        cycle_count = 0;
   bit        stall_enable = 1'b1;

   grid_index_converter_top DUT (.*);

   always #5 clock = ~clock;

   // hard stop on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_points.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // gap length: mostly short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // effective axis size: inactive or zero counts as one, large saturates
   function automatic longint axis_len(logic [PTS_W-1:0] p, bit active);
      if (!active || p == 0) return 1;
      if (p > MAX_PTS) return MAX_PTS;
      return p;
   endfunction

   // compute what the converter must return for one item
   function automatic point_type convert_point(bit mode, logic [LIN_W-1:0] lin_in,
                                               logic [CRD_W-1:0] xi, logic [CRD_W-1:0] yi,
                                               logic [CRD_W-1:0] zi);
      point_type  p;
      bit         use_y, use_z, bad;
      longint     nx, ny, nz, plane, idx, x, y, z, r, lin;
      logic [1:0] d;
      p = '0;
      d = (grid_dims == 0) ? 2'd1 : grid_dims;
      use_y = d >= 2;
      use_z = d >= 3;
      nx = axis_len(grid_pts[0], 1'b1);
      ny = axis_len(grid_pts[1], use_y);
      nz = axis_len(grid_pts[2], use_z);
      plane = nx * ny;
      x = 0; y = 0; z = 0; lin = 0;
      if (mode == 1'b0) begin
         idx = lin_in;
         bad = idx >= plane * nz;
         if (!bad) begin
            z = idx / plane;
            r = idx - z * plane;
            y = r / nx;
            x = r % nx;
            lin = idx;
         end
      end else begin
         x = xi;
         y = use_y ? yi : 0;
         z = use_z ? zi : 0;
         bad = x >= nx || y >= ny || z >= nz;
         if (!bad) lin = x + nx * (y + ny * z);
      end
      if (bad) begin
         p.err = 1'b1;
         return p;
      end
      p.lin = lin[LIN_W-1:0];
      p.x = x[CRD_W-1:0];
      p.y = y[CRD_W-1:0];
      p.z = z[CRD_W-1:0];
      p.boundary = (x == 0 || x == nx - 1) || (use_y && (y == 0 || y == ny - 1)) ||
                   (use_z && (z == 0 || z == nz - 1));
      p.px = POS_W'(x * grid_step[0]);
      p.py = use_y ? POS_W'(y * grid_step[1]) : '0;
      p.pz = use_z ? POS_W'(z * grid_step[2]) : '0;
      return p;
   endfunction

   // send one item, record its expectation at acceptance; valid stays up
   // for a back-to-back follower and drops only when a gap comes
   task automatic send_item(bit mode, logic [LIN_W-1:0] lin_in, logic [CRD_W-1:0] xi,
                            logic [CRD_W-1:0] yi, logic [CRD_W-1:0] zi);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, zi, yi, xi, lin_in};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_points.push_back(convert_point(mode, lin_in, xi, yi, zi));
      items_sent++;
   endtask

   // APB write: setup then access, shadow updated at the write edge;
   // the bus is left selected so writes can follow back to back
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_DIMS:   grid_dims    = value[1:0];
         REG_PTS_X:  grid_pts[0]  = value[PTS_W-1:0];
         REG_PTS_Y:  grid_pts[1]  = value[PTS_W-1:0];
         REG_PTS_Z:  grid_pts[2]  = value[PTS_W-1:0];
         REG_STEP_X: grid_step[0] = value[STEP_W-1:0];
         REG_STEP_Y: grid_step[1] = value[STEP_W-1:0];
         REG_STEP_Z: grid_step[2] = value[STEP_W-1:0];
         default: ;
      endcase
   endtask

   // let the pipe empty before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_grid(logic [1:0] d, int px, int py, int pz,
                           int sx, int sy, int sz);
      drain();
      write_reg(REG_DIMS, 32'(d));
      write_reg(REG_PTS_X, px);
      write_reg(REG_PTS_Y, py);
      write_reg(REG_PTS_Z, pz);
      write_reg(REG_STEP_X, sx);
      write_reg(REG_STEP_Y, sy);
      write_reg(REG_STEP_Z, sz);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // sink side: random back-pressure
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!stall_enable) begin
            rsp_tready <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // check every result against the oldest expectation
   always @(posedge clock) begin
      point_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = point_type'(rsp_tdata[163:0]);
         points_seen++;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_points.pop_front();
            if (want.err) error_points++;
            if (got.lin !== want.lin || got.x !== want.x || got.y !== want.y ||
                got.z !== want.z || got.boundary !== want.boundary ||
                got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
                got.err !== want.err || rsp_tdata[RSP_DATA_W-1:164] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch #%0d: lin %0d/%0d xyz %0d,%0d,%0d/%0d,%0d,%0d",
                            " bnd %b/%b\n pos %h,%h,%h/%h,%h,%h err %b/%b"},
                           points_seen, want.lin, got.lin, want.x, want.y, want.z,
                           got.x, got.y, got.z, want.boundary, got.boundary,
                           want.px, want.py, want.pz, got.px, got.py, got.pz,
                           want.err, got.err);
            end
         end
      end
   end

   // corner cases at the reset configuration
   task automatic test_reset_grid();
      grid_dims = 2'd3;
      grid_pts = '{11'd1024, 11'd1024, 11'd1024};
      grid_step = '{24'd65536, 24'd65536, 24'd65536};
      send_item(1'b0, 30'd0, '0, '0, '0);
      send_item(1'b0, 30'h3FFFFFFF, '0, '0, '0);
      send_item(1'b0, 30'd524800, '0, '0, '0);
      send_item(1'b1, '0, 10'd1023, 10'd1023, 10'd1023);
      send_item(1'b1, '0, 10'd512, 10'd1, 10'd700);
      send_item(1'b1, '0, 10'h3FF, 10'h2AA, 10'h155);
   endtask

   // zero and oversize counts, zero dimensions, ignored inputs, extreme steps
   task automatic test_special_sizes();
      set_grid(2'd0, 0, 5, 5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_item(1'b0, 30'd0, '0, '0, '0);
      send_item(1'b0, 30'd1, '0, '0, '0);
      send_item(1'b1, '0, 10'd0, 10'd1023, 10'd1023);
      set_grid(2'd2, 11'h7FF, 2000, 1, 24'hFFFFFF, 0, 24'h123456);
      send_item(1'b1, '0, 10'd1023, 10'd1023, 10'd1023);
      send_item(1'b0, 30'd1048575, '0, '0, '0);
      send_item(1'b0, 30'd1048576, '0, '0, '0);
      send_item(1'b1, '0, 10'd5, 10'd0, 10'd0);
      set_grid(2'd3, 1, 1, 1, 0, 0, 0);
      send_item(1'b0, 30'd0, '0, '0, '0);
      send_item(1'b0, 30'd1, '0, '0, '0);
      send_item(1'b1, '0, 10'd0, 10'd0, 10'd1);
      set_grid(2'd3, 3, 4, 5, 24'h018000, 24'h000001, 24'hFFFFFF);
      send_item(1'b0, 30'd59, '0, '0, '0);
      send_item(1'b0, 30'd60, '0, '0, '0);
      send_item(1'b1, '0, 10'd1, 10'd2, 10'd3);
      send_item(1'b1, '0, 10'd3, 10'd0, 10'd0);
   endtask

   // random configurations, mostly in-range items with random content
   task automatic test_random_sweep(int total);
      int sent, phase_len, kind, nx, ny, nz, span;
      sent = 0;
      while (sent < total) begin
         kind = $urandom_range(0, 9);
         nx = (kind == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
         ny = (kind == 1) ? 1024 : $urandom_range(0, 40);
         nz = (kind == 2) ? $urandom_range(1000, 2047) : $urandom_range(0, 40);
         set_grid(2'($urandom_range(0, 3)), nx, ny, nz,
                  $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                  $urandom_range(0, 24'hFFFFFF));
         stall_enable = ($urandom_range(0, 3) != 0);
         span = int'(axis_len(grid_pts[0], 1) * axis_len(grid_pts[1], grid_dims != 1) *
                     axis_len(grid_pts[2], grid_dims == 3));
         phase_len = $urandom_range(40, 120);
         for (int i = 0; i < phase_len && sent < total; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
               send_item(1'b0, LIN_W'($urandom_range(0, span - 1)), CRD_W'($urandom),
                         CRD_W'($urandom), CRD_W'($urandom));
            else if (kind < 8)
               send_item(1'b1, LIN_W'($urandom),
                         CRD_W'($urandom_range(0, axis_len(grid_pts[0], 1) - 1)),
                         CRD_W'($urandom_range(0, axis_len(grid_pts[1], 1) - 1)),
                         CRD_W'($urandom_range(0, axis_len(grid_pts[2], 1) - 1)));
            else
               send_item(1'($urandom), LIN_W'($urandom), CRD_W'($urandom),
                         CRD_W'($urandom), CRD_W'($urandom));
            sent++;
         end
      end
      stall_enable = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_grid();
      test_special_sizes();
      test_random_sweep(1850);
      drain();
      repeat (LATENCY + 5) @(posedge clock);
      $display("Sent %0d items over random grid setups; %0d results checked, %0d range errors.",
               items_sent, points_seen, error_points);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  expected_points.size());
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
